### rtl/core/carrier_frequency_scheduler_defines.svh
// ----------------------------------------------------------------------------
// carrier frequency scheduler assertion macros
// shared property shapes used by the checker
// ----------------------------------------------------------------------------
`ifndef CARRIER_FREQUENCY_SCHEDULER_DEFINES_SVH
`define CARRIER_FREQUENCY_SCHEDULER_DEFINES_SVH

// same-cycle implication, reset disables the check
`define CFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cfs check failed");

// next-cycle implication, reset disables the check
`define CFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cfs check failed");

`endif

### rtl/core/cfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_pkg
// types, constants and register codes of the carrier frequency scheduler
// ----------------------------------------------------------------------------
package cfs_pkg;

	localparam int SPEED_W   = 16;
	localparam int FC_W      = 14;
	localparam int HOST_W    = 16;
	localparam int STEP_W    = 10;
	localparam int NUM_W     = 27;
	localparam int HP_W      = 16;
	localparam int NS_W      = 20;
	localparam int DC_W      = 17;
	localparam int TGT_W     = 16;
	localparam int PROD_W    = FC_W + HP_W;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HOST_FC   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FC    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FC    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UP_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_STEP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_NUM = 3'd5;

	// register reset values
	localparam logic [HOST_W-1:0] RST_HOST_FC   = 16'd0;
	localparam logic [FC_W-1:0]   RST_MIN_FC    = 14'd1500;
	localparam logic [FC_W-1:0]   RST_MAX_FC    = 14'd10000;
	localparam logic [STEP_W-1:0] RST_UP_STEP   = 10'd100;
	localparam logic [STEP_W-1:0] RST_DOWN_STEP = 10'd1;
	localparam logic [NUM_W-1:0]  RST_PERIOD_NUM = 27'd90000000;

	// carrier bands and bounds in Hz
	localparam logic [TGT_W-1:0] FC_LOW_BAND  = 16'd2000;
	localparam logic [TGT_W-1:0] FC_MID1_BAND = 16'd5000;
	localparam logic [TGT_W-1:0] FC_MID2_BAND = 16'd7000;
	localparam logic [TGT_W-1:0] FC_MID3_BAND = 16'd8500;
	localparam logic [TGT_W-1:0] FC_TOP_BAND  = 16'd10000;
	localparam logic [TGT_W-1:0] FC_FLOOR     = 16'd1500;
	localparam logic [TGT_W-1:0] FC_CEIL      = 16'd12000;

	// speed band edges, Q.4 Hz
	localparam int HYST_Q4  = 10 * 16;
	localparam int EDGE1_Q4 = 70 * 16;
	localparam int EDGE2_Q4 = 120 * 16;
	localparam int EDGE3_Q4 = 250 * 16;
	localparam int EDGE4_Q4 = 400 * 16;

	// shared divider, two quotient bits per cycle
	localparam int DIV_W     = 36;
	localparam int DIVR_W    = 15;
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// 2 * 1e9 for the rounded nanosecond period
	localparam logic [DIV_W-1:0]  NS_NUMER   = 36'd2000000000;
	// fc*hp*768/1e6 rounded reduces to (24*p + 15625) / 31250
	localparam logic [DIV_W-1:0]  DC_BIAS    = 36'd15625;
	localparam logic [DIVR_W-1:0] DC_DIVISOR = 15'd31250;

	typedef struct packed {
		logic signed [SPEED_W-1:0] speed;
		logic                      torque_mode;
		logic                      calibrated;
	} in_t;

	typedef struct packed {
		logic [FC_W-1:0] applied_fc;
		logic [HP_W-1:0] half_period;
		logic [NS_W-1:0] sample_period_ns;
		logic [DC_W-1:0] dead_comp;
	} out_t;

	typedef struct packed {
		logic [HOST_W-1:0] host_fc;
		logic [FC_W-1:0]   min_fc;
		logic [FC_W-1:0]   max_fc;
		logic [STEP_W-1:0] up_step;
		logic [STEP_W-1:0] down_step;
		logic [NUM_W-1:0]  period_numerator;
	} cfg_t;

	typedef struct packed {
		logic tgt_en;
		logic app_en;
	} freq_ctl_t;

endpackage

### rtl/core/cfs_freq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_freq
// target band selection with hysteresis, clamp, slew and final bound
// ----------------------------------------------------------------------------
module cfs_freq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfs_pkg::freq_ctl_t            ctl,
	input  cfs_pkg::in_t                  req,
	input  cfs_pkg::cfg_t                 cfg,
	output logic [cfs_pkg::FC_W-1:0]      applied
);

	logic [cfs_pkg::SPEED_W-1:0] spd_abs;
	logic [cfs_pkg::TGT_W-1:0]   tgt_raw;
	logic [cfs_pkg::TGT_W-1:0]   tgt_clamp;
	logic [cfs_pkg::TGT_W-1:0]   target_q;
	logic [cfs_pkg::FC_W-1:0]    applied_q;
	logic [cfs_pkg::TGT_W-1:0]   app16;
	logic [cfs_pkg::TGT_W:0]     sum_up;
	logic [cfs_pkg::TGT_W:0]     lim_dn;
	logic [cfs_pkg::TGT_W-1:0]   app_slew;
	logic [cfs_pkg::TGT_W-1:0]   app_mode;
	logic [cfs_pkg::TGT_W-1:0]   app_bound;

	// magnitude of the speed, the most negative code maps to its unsigned value
	assign spd_abs = req.speed[cfs_pkg::SPEED_W-1] ?
		(~req.speed + cfs_pkg::SPEED_W'(1)) : req.speed;

	always_comb begin
		tgt_raw = target_q;
		if (!req.torque_mode) begin
			tgt_raw = cfs_pkg::FC_TOP_BAND;
		end else if (!req.calibrated) begin
			tgt_raw = cfg.host_fc;
		end else if (spd_abs < cfs_pkg::SPEED_W'(cfs_pkg::EDGE1_Q4 - cfs_pkg::HYST_Q4)) begin
			tgt_raw = cfs_pkg::FC_LOW_BAND;
		end else if (spd_abs < cfs_pkg::SPEED_W'(cfs_pkg::EDGE1_Q4)) begin
			tgt_raw = target_q;
		end else if (spd_abs < cfs_pkg::SPEED_W'(cfs_pkg::EDGE2_Q4 - cfs_pkg::HYST_Q4)) begin
			tgt_raw = cfs_pkg::FC_MID1_BAND;
		end else if (spd_abs < cfs_pkg::SPEED_W'(cfs_pkg::EDGE2_Q4)) begin
			tgt_raw = target_q;
		end else if (spd_abs < cfs_pkg::SPEED_W'(cfs_pkg::EDGE3_Q4 - cfs_pkg::HYST_Q4)) begin
			tgt_raw = cfs_pkg::FC_MID2_BAND;
		end else if (spd_abs < cfs_pkg::SPEED_W'(cfs_pkg::EDGE3_Q4)) begin
			tgt_raw = target_q;
		end else if (spd_abs < cfs_pkg::SPEED_W'(cfs_pkg::EDGE4_Q4 - cfs_pkg::HYST_Q4)) begin
			tgt_raw = cfs_pkg::FC_MID3_BAND;
		end else if (spd_abs < cfs_pkg::SPEED_W'(cfs_pkg::EDGE4_Q4)) begin
			tgt_raw = target_q;
		end else begin
			tgt_raw = cfs_pkg::FC_TOP_BAND;
		end

		// max is checked first: when the limits cross, targets above max get max, all others get min
		if (tgt_raw > cfs_pkg::TGT_W'(cfg.max_fc)) begin
			tgt_clamp = cfs_pkg::TGT_W'(cfg.max_fc);
		end else if (tgt_raw < cfs_pkg::TGT_W'(cfg.min_fc)) begin
			tgt_clamp = cfs_pkg::TGT_W'(cfg.min_fc);
		end else begin
			tgt_clamp = tgt_raw;
		end
	end

	assign app16  = cfs_pkg::TGT_W'(applied_q);
	assign sum_up = {1'b0, app16} + (cfs_pkg::TGT_W + 1)'(cfg.up_step);
	assign lim_dn = {1'b0, target_q} + (cfs_pkg::TGT_W + 1)'(cfg.down_step);

	always_comb begin
		if (app16 == target_q) begin
			app_slew = app16;
		end else if (sum_up <= {1'b0, target_q}) begin
			app_slew = sum_up[cfs_pkg::TGT_W-1:0];
		end else if (app16 < target_q) begin
			app_slew = target_q;
		end else if ({1'b0, app16} >= lim_dn) begin
			app_slew = app16 - cfs_pkg::TGT_W'(cfg.down_step);
		end else begin
			app_slew = target_q;
		end

		app_mode = req.torque_mode ? app_slew : cfs_pkg::FC_TOP_BAND;

		if (app_mode > cfs_pkg::FC_CEIL) begin
			app_bound = cfs_pkg::FC_CEIL;
		end else if (app_mode < cfs_pkg::FC_FLOOR) begin
			app_bound = cfs_pkg::FC_FLOOR;
		end else begin
			app_bound = app_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			applied_q <= '0;
		end else begin
			if (ctl.tgt_en) begin
				target_q <= tgt_clamp;
			end
			if (ctl.app_en) begin
				applied_q <= app_bound[cfs_pkg::FC_W-1:0];
			end
		end
	end

	assign applied = applied_q;

endmodule

### rtl/core/cfs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_div
// shared restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module cfs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cfs_pkg::DIV_W-1:0]     dividend,
	input  logic [cfs_pkg::DIVR_W-1:0]    divisor,
	output logic                          done,
	output logic [cfs_pkg::DIV_W-1:0]     quotient
);

	logic [cfs_pkg::DIVR_W-1:0]    dvs_q;
	logic [cfs_pkg::DIVR_W-1:0]    rem_q;
	logic [cfs_pkg::DIV_W-1:0]     quo_q;
	logic [cfs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [cfs_pkg::DIVR_W:0]      r1;
	logic [cfs_pkg::DIVR_W:0]      r2;
	logic                          ge1;
	logic                          ge2;
	logic [cfs_pkg::DIVR_W:0]      rem1;
	logic [cfs_pkg::DIVR_W:0]      rem2;

	// dividend bits shift out of the top of quo_q while quotient bits enter below
	always_comb begin
		r1   = {rem_q, quo_q[cfs_pkg::DIV_W-1]};
		ge1  = r1 >= {1'b0, dvs_q};
		rem1 = ge1 ? (r1 - {1'b0, dvs_q}) : r1;
		r2   = {rem1[cfs_pkg::DIVR_W-1:0], quo_q[cfs_pkg::DIV_W-2]};
		ge2  = r2 >= {1'b0, dvs_q};
		rem2 = ge2 ? (r2 - {1'b0, dvs_q}) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == cfs_pkg::DIV_CNT_W'(cfs_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + cfs_pkg::DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem2[cfs_pkg::DIVR_W-1:0];
			quo_q <= {quo_q[cfs_pkg::DIV_W-3:0], ge1, ge2};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/core/carrier_frequency_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// carrier_frequency_scheduler
// per-tick PWM carrier frequency selection with slew and timing terms
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one request per control tick: speed (Q.4 Hz),
//   torque_mode and calibrated. A request is taken when in_valid is high and
//   in_stall is low. The block holds in_stall high while it works on one.
//   out_valid/out_stall deliver one result per request: applied_fc,
//   half_period, sample_period_ns and dead_comp. A result is taken when
//   out_valid is high and out_stall is low; while stalled it holds.
//   cfg_valid/cfg_ready write register cfg_index with cfg_data; write only
//   while no request is in flight. cfg_ready is always high.
// Sequence:
//   a request passes target selection and slew, then three divisions in
//   the shared divider, with a multiply before the last; the divider runs
//   at two quotient bits per cycle. A new request waits until the result
//   is in the output register. A finished result sits in the output
//   register, so the next request is accepted while it waits; the block
//   then holds its next result until the output register frees.
// Reset:
//   arst_n clears the held target and applied frequency to zero, loads the
//   register defaults and empties the output register.
// ----------------------------------------------------------------------------
module carrier_frequency_scheduler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  cfs_pkg::in_t                     in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output cfs_pkg::out_t                    out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cfs_pkg::NUM_W-1:0]        cfg_data
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_TGT    = 4'd1;
	localparam logic [3:0] ST_SLEW   = 4'd2;
	localparam logic [3:0] ST_HP_GO  = 4'd3;
	localparam logic [3:0] ST_HP_RUN = 4'd4;
	localparam logic [3:0] ST_NS_GO  = 4'd5;
	localparam logic [3:0] ST_NS_RUN = 4'd6;
	localparam logic [3:0] ST_MUL    = 4'd7;
	localparam logic [3:0] ST_DC_GO  = 4'd8;
	localparam logic [3:0] ST_DC_RUN = 4'd9;
	localparam logic [3:0] ST_OUT    = 4'd10;

	logic [3:0]                     state_q;
	cfs_pkg::cfg_t                  cfg_q;
	cfs_pkg::in_t                   req_q;
	cfs_pkg::freq_ctl_t             fctl;
	logic [cfs_pkg::FC_W-1:0]       applied;
	logic [cfs_pkg::HP_W-1:0]       hp_q;
	logic [cfs_pkg::NS_W-1:0]       ns_q;
	logic [cfs_pkg::PROD_W-1:0]     prod_q;
	cfs_pkg::out_t                  out_q;
	logic                           out_valid_q;

	logic                           div_start;
	logic [cfs_pkg::DIV_W-1:0]      div_dividend;
	logic [cfs_pkg::DIVR_W-1:0]     div_divisor;
	logic                           div_done;
	logic [cfs_pkg::DIV_W-1:0]      div_quo;
	logic [cfs_pkg::DC_W-1:0]       dc_sat;
	logic                           out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.host_fc          <= cfs_pkg::RST_HOST_FC;
			cfg_q.min_fc           <= cfs_pkg::RST_MIN_FC;
			cfg_q.max_fc           <= cfs_pkg::RST_MAX_FC;
			cfg_q.up_step          <= cfs_pkg::RST_UP_STEP;
			cfg_q.down_step        <= cfs_pkg::RST_DOWN_STEP;
			cfg_q.period_numerator <= cfs_pkg::RST_PERIOD_NUM;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cfs_pkg::REG_HOST_FC: begin
					cfg_q.host_fc <= cfg_data[cfs_pkg::HOST_W-1:0];
				end
				cfs_pkg::REG_MIN_FC: begin
					cfg_q.min_fc <= cfg_data[cfs_pkg::FC_W-1:0];
				end
				cfs_pkg::REG_MAX_FC: begin
					cfg_q.max_fc <= cfg_data[cfs_pkg::FC_W-1:0];
				end
				cfs_pkg::REG_UP_STEP: begin
					cfg_q.up_step <= cfg_data[cfs_pkg::STEP_W-1:0];
				end
				cfs_pkg::REG_DOWN_STEP: begin
					cfg_q.down_step <= cfg_data[cfs_pkg::STEP_W-1:0];
				end
				cfs_pkg::REG_PERIOD_NUM: begin
					cfg_q.period_numerator <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign fctl.tgt_en = (state_q == ST_TGT);
	assign fctl.app_en = (state_q == ST_SLEW);

	cfs_freq u_freq (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fctl),
		.req     (req_q),
		.cfg     (cfg_q),
		.applied (applied)
	);

	// all divisions are round half up: (2n + d) / (2d)
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = {applied, 1'b0};
		unique case (state_q)
			ST_HP_GO: begin
				div_start    = 1'b1;
				div_dividend = cfs_pkg::DIV_W'({cfg_q.period_numerator, 1'b0})
					+ cfs_pkg::DIV_W'(applied);
			end
			ST_NS_GO: begin
				div_start    = 1'b1;
				div_dividend = cfs_pkg::NS_NUMER + cfs_pkg::DIV_W'(applied);
			end
			ST_DC_GO: begin
				div_start    = 1'b1;
				div_dividend = cfs_pkg::DIV_W'({prod_q, 4'b0})
					+ cfs_pkg::DIV_W'({prod_q, 3'b0}) + cfs_pkg::DC_BIAS;
				div_divisor  = cfs_pkg::DC_DIVISOR;
			end
			default: begin
			end
		endcase
	end

	cfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// the divider keeps the dead-time quotient until its next start
	assign dc_sat = (|div_quo[cfs_pkg::DIV_W-1:cfs_pkg::DC_W]) ? '1
		: div_quo[cfs_pkg::DC_W-1:0];

	assign out_load = (state_q == ST_OUT) && div_done == 1'b0
		&& (!out_valid_q || !out_stall);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_TGT;
					end
				end
				ST_TGT:    state_q <= ST_SLEW;
				ST_SLEW:   state_q <= ST_HP_GO;
				ST_HP_GO:  state_q <= ST_HP_RUN;
				ST_HP_RUN: begin
					if (div_done) begin
						state_q <= ST_NS_GO;
					end
				end
				ST_NS_GO:  state_q <= ST_NS_RUN;
				ST_NS_RUN: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:    state_q <= ST_DC_GO;
				ST_DC_GO:  state_q <= ST_DC_RUN;
				ST_DC_RUN: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			req_q <= in_data;
		end
		if (state_q == ST_HP_RUN && div_done) begin
			hp_q <= (|div_quo[cfs_pkg::DIV_W-1:cfs_pkg::HP_W]) ? '1
				: div_quo[cfs_pkg::HP_W-1:0];
		end
		if (state_q == ST_NS_RUN && div_done) begin
			ns_q <= (|div_quo[cfs_pkg::DIV_W-1:cfs_pkg::NS_W]) ? '1
				: div_quo[cfs_pkg::NS_W-1:0];
		end
		if (state_q == ST_MUL) begin
			prod_q <= cfs_pkg::PROD_W'(applied) * cfs_pkg::PROD_W'(hp_q);
		end
		if (out_load) begin
			out_q.applied_fc       <= applied;
			out_q.half_period      <= hp_q;
			out_q.sample_period_ns <= ns_q;
			out_q.dead_comp        <= dc_sat;
		end
	end

endmodule

### rtl/core/cfs_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_chk
// port-level checks of the carrier frequency scheduler
// ----------------------------------------------------------------------------
`include "carrier_frequency_scheduler_defines.svh"

module cfs_chk (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  cfs_pkg::in_t                     in_data,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  cfs_pkg::out_t                    out_data,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [cfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cfs_pkg::NUM_W-1:0]        cfg_data
);

	// a stalled result holds
	`CFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// one request at a time: busy right after a request
	`CFS_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && !in_stall, in_stall)

	// applied frequency stays inside the hard bounds
	`CFS_ASSERT_SAME(a_fc_bound, clk, arst_n, out_valid, out_data.applied_fc >= 14'd1500 && out_data.applied_fc <= 14'd12000)

	// period in ns matches the bounded frequency range
	`CFS_ASSERT_SAME(a_ns_bound, clk, arst_n, out_valid, out_data.sample_period_ns >= 20'd83333 && out_data.sample_period_ns <= 20'd666667)

endmodule

bind carrier_frequency_scheduler cfs_chk u_cfs_chk (.*);
